### rtl/core/call_auction_price_discovery_macros.svh
// assertion helpers for the call auction block
`ifndef CALL_AUCTION_PRICE_DISCOVERY_MACROS_SVH
`define CALL_AUCTION_PRICE_DISCOVERY_MACROS_SVH
`ifndef SYNTHESIS
`define CAPD_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define CAPD_ASSERT_NR(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define CAPD_ASSERT(label, clk, rst, prop, msg)
`define CAPD_ASSERT_NR(label, clk, prop, msg)
`endif
`endif

### rtl/core/capd_pkg.sv
package capd_pkg;
   localparam int LevelBits  = 10;
   localparam int Levels     = 1 << LevelBits;
   localparam int VolBits    = 48;
   localparam int PriceBits  = 32;
   localparam int TickBits   = 16;
   localparam int CsrIdxBits = 2;
   localparam int CntBits    = LevelBits + 1;
   localparam int SumBits    = PriceBits + CntBits;

   localparam logic [1:0] OP_UPDATE  = 2'd0;
   localparam logic [1:0] OP_COMPUTE = 2'd1;
   localparam logic [1:0] OP_CLEAR   = 2'd2;
   localparam logic [1:0] OP_UNUSED  = 2'd3;

   localparam logic [CsrIdxBits-1:0] CSR_REF  = 2'd0;
   localparam logic [CsrIdxBits-1:0] CSR_BASE = 2'd1;
   localparam logic [CsrIdxBits-1:0] CSR_TICK = 2'd2;
   localparam logic [CsrIdxBits-1:0] CSR_MODE = 2'd3;

   localparam logic [VolBits-1:0] VolMax = {VolBits{1'b1}};

   function automatic logic [VolBits-1:0] sat_add(input logic [VolBits-1:0] a,
                                                 input logic [VolBits-1:0] b);
      logic [VolBits:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[VolBits] ? VolMax : s[VolBits-1:0];
   endfunction
endpackage

### rtl/core/capd_ram.sv
module capd_ram #(
   parameter int Width = 8,
   parameter int Depth = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end
   assign rd_data = rd_data_ff;
endmodule

### rtl/core/capd_divider.sv
// restoring divider, one quotient bit per cycle
module capd_divider (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [capd_pkg::SumBits+7:0]  dividend,
   input  logic [capd_pkg::CntBits+6:0]  divisor,
   output logic                          done,
   output logic [capd_pkg::SumBits+7:0]  quotient
);
   localparam int NBits = capd_pkg::SumBits + 8;
   localparam int DBits = capd_pkg::CntBits + 7;

   logic [NBits-1:0] quo_ff, quo_in;
   logic [DBits:0]   rem_ff, rem_in;
   logic [DBits-1:0] div_ff, div_in;
   logic [6:0]       cnt_ff, cnt_in;
   logic             run_ff, run_in;
   logic             done_ff, done_in;
   logic [DBits:0]   trial;

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      trial   = {rem_ff[DBits-1:0], quo_ff[NBits-1]};
      if (start) begin
         quo_in = dividend;
         rem_in = '0;
         div_in = divisor;
         cnt_in = 7'(NBits);
         run_in = 1'b1;
      end else if (run_ff) begin
         quo_in = {quo_ff[NBits-2:0], 1'b0};
         if (trial >= {1'b0, div_ff}) begin
            rem_in    = trial - {1'b0, div_ff};
            quo_in[0] = 1'b1;
         end else begin
            rem_in = trial;
         end
         cnt_in = cnt_ff - 7'd1;
         if (cnt_ff == 7'd1) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
      cnt_ff <= cnt_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;
endmodule

### rtl/core/call_auction_price_discovery.sv
// One word per start pulse, taken only while busy is low. A volume update reads
// the level memory in ST_UPRD and writes it back in ST_UPWR, which also registers
// its result word (underflow set when the decrease exceeded the stored volume)
// onto the result ports. A compute word walks the level memories twice, once
// from the top level down to store the buy volume strictly above each level and
// once upward to evaluate each level; busy stays high throughout and the result
// word is registered onto the result ports as busy falls. Rule mode 1 adds a pass
// through the averaging divider. A clear word, and reset, start a clearing pass
// that writes zero into every level of the buy and sell memories, with busy high
// throughout and no result word; an unused op code is dropped. Results appear
// for one cycle under rsp_valid and cannot be held off by the receiver.
`include "call_auction_price_discovery_macros.svh"
module call_auction_price_discovery (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  logic [1:0]                            req_op,
   input  logic                                  req_side,
   input  logic [capd_pkg::LevelBits-1:0]        req_level,
   input  logic signed [capd_pkg::VolBits-1:0]   req_delta,
   output logic                                  rsp_valid,
   output logic [capd_pkg::PriceBits-1:0]        rsp_price,
   output logic [capd_pkg::VolBits-1:0]          rsp_matched_volume,
   output logic                                  rsp_found,
   output logic                                  rsp_underflow,
   input  logic                                  csr_write,
   input  logic [capd_pkg::CsrIdxBits-1:0]       csr_index,
   input  logic [31:0]                           csr_data
);
   localparam int LB = capd_pkg::LevelBits;
   localparam int VB = capd_pkg::VolBits;
   localparam int PB = capd_pkg::PriceBits;
   localparam int CB = capd_pkg::CntBits;
   localparam int SB = capd_pkg::SumBits;

   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_CLR   = 4'd1;
   localparam logic [3:0] ST_UPRD  = 4'd2;
   localparam logic [3:0] ST_UPWR  = 4'd3;
   localparam logic [3:0] ST_DOWN  = 4'd4;
   localparam logic [3:0] ST_DLAST = 4'd5;
   localparam logic [3:0] ST_UP    = 4'd6;
   localparam logic [3:0] ST_ULAST = 4'd7;
   localparam logic [3:0] ST_FIN   = 4'd8;
   localparam logic [3:0] ST_DIV   = 4'd9;
   localparam logic [3:0] ST_PX    = 4'd10;

   logic [PB-1:0] ref_ff, base_ff;
   logic [15:0]   tick_ff;
   logic          mode_ff;

   logic [3:0]    st_ff, st_in;
   logic [LB-1:0] idx_ff, idx_in;
   logic          side_ff, side_in;
   logic [LB-1:0] lvl_ff, lvl_in;
   logic [VB-1:0] delta_ff, delta_in;

   // cumulative sums
   logic [VB-1:0] bacc_ff, bacc_in;   // buy at or above during down pass
   logic [VB-1:0] down_ff, down_in;
   logic          anyb_ff, anyb_in, anys_ff, anys_in;
   logic          found_ff, found_in;
   logic [VB-1:0] bvol_ff, bvol_in, bdiff_ff, bdiff_in;
   logic [PB-1:0] bpx_ff, bpx_in;
   logic [PB:0]   bdist_ff, bdist_in;
   logic [SB-1:0] psum_ff, psum_in;
   logic [CB-1:0] pcnt_ff, pcnt_in;
   logic [PB+LB+16:0] pxacc_ff, pxacc_in;

   logic          rv_ff, rv_in;
   logic [PB-1:0] rpx_ff, rpx_in;
   logic [VB-1:0] rvol_ff, rvol_in;
   logic          rfnd_ff, rfnd_in, runf_ff, runf_in;

   // memories: buy, sell, buy strictly above each level
   logic          bwe, swe, cwe;
   logic [LB-1:0] waddr, raddr, cwaddr, craddr;
   logic [VB-1:0] bwd, swd, cwd;
   logic [VB-1:0] brd, srd, crd;

   capd_ram #(.Width(VB), .Depth(capd_pkg::Levels)) u_buy (
      .clock, .wr_en(bwe), .wr_addr(waddr), .wr_data(bwd), .rd_addr(raddr), .rd_data(brd));
   capd_ram #(.Width(VB), .Depth(capd_pkg::Levels)) u_sell (
      .clock, .wr_en(swe), .wr_addr(waddr), .wr_data(swd), .rd_addr(raddr), .rd_data(srd));
   capd_ram #(.Width(VB), .Depth(capd_pkg::Levels)) u_cum (
      .clock, .wr_en(cwe), .wr_addr(cwaddr), .wr_data(cwd), .rd_addr(craddr), .rd_data(crd));

   logic          div_start, div_done;
   logic [SB+7:0] div_q;
   logic [SB+7:0] div_n;
   logic [CB+6:0] div_d;

   capd_divider u_div (
      .clock, .reset, .start(div_start), .dividend(div_n), .divisor(div_d),
      .done(div_done), .quotient(div_q));

   assign div_n = (SB+8)'(psum_ff) + (SB+8)'(pcnt_ff) * (SB+8)'(50);
   assign div_d = (CB+7)'(pcnt_ff) * (CB+7)'(100);

   // update arithmetic
   logic [VB-1:0] cur, mag, newv;
   logic          neg, under;
   // scan arithmetic
   logic [VB-1:0] bsum, ssum, up, vol, diff;
   logic          trad, better;
   logic [PB-1:0] px;
   logic [PB:0]   gap;
   logic [SB+7:0] qx100;

   always_comb begin
      cur   = side_ff ? srd : brd;
      neg   = delta_ff[VB-1];
      mag   = -delta_ff;
      under = neg && (mag > cur);
      newv  = neg ? (under ? '0 : cur - mag) : capd_pkg::sat_add(cur, delta_ff);

      // cum memory holds buy strictly above the level; add the level for at-or-above
      up   = crd;
      bsum = capd_pkg::sat_add(crd, brd);
      ssum = capd_pkg::sat_add(down_ff, srd);
      trad = (up <= ssum) && (down_ff <= bsum);
      vol  = (bsum < ssum) ? bsum : ssum;
      diff = (bsum >= ssum) ? bsum - ssum : ssum - bsum;
      px   = (pxacc_ff > (PB+LB+17)'({PB{1'b1}})) ? {PB{1'b1}} : pxacc_ff[PB-1:0];
      gap  = (px >= ref_ff) ? {1'b0, px - ref_ff} : {1'b0, ref_ff - px};
      if (!found_ff) better = 1'b1;
      else if (vol != bvol_ff) better = vol > bvol_ff;
      else if (diff != bdiff_ff) better = diff < bdiff_ff;
      else better = !mode_ff && (gap < bdist_ff);
      qx100 = div_q * (SB+8)'(100);
   end

   always_comb begin
      st_in = st_ff; idx_in = idx_ff; side_in = side_ff; lvl_in = lvl_ff;
      delta_in = delta_ff; bacc_in = bacc_ff; down_in = down_ff;
      anyb_in = anyb_ff; anys_in = anys_ff; found_in = found_ff;
      bvol_in = bvol_ff; bdiff_in = bdiff_ff; bpx_in = bpx_ff; bdist_in = bdist_ff;
      psum_in = psum_ff; pcnt_in = pcnt_ff; pxacc_in = pxacc_ff;
      rv_in = 1'b0; rpx_in = rpx_ff; rvol_in = rvol_ff; rfnd_in = rfnd_ff;
      runf_in = runf_ff;
      bwe = 1'b0; swe = 1'b0; cwe = 1'b0;
      waddr = idx_ff; bwd = '0; swd = '0; raddr = idx_ff;
      cwaddr = idx_ff; cwd = '0; craddr = idx_ff;
      div_start = 1'b0;
      case (st_ff)
         ST_IDLE: begin
            if (start) begin
               side_in = req_side; lvl_in = req_level; delta_in = req_delta;
               case (req_op)
                  capd_pkg::OP_UPDATE: st_in = ST_UPRD;
                  capd_pkg::OP_COMPUTE: begin
                     st_in = ST_DOWN; idx_in = '1; bacc_in = '0;
                     anyb_in = 1'b0; anys_in = 1'b0;
                  end
                  capd_pkg::OP_CLEAR: begin
                     st_in = ST_CLR; idx_in = '0;
                  end
                  default: st_in = ST_IDLE;
               endcase
            end
         end
         ST_CLR: begin
            bwe = 1'b1; swe = 1'b1;
            idx_in = idx_ff + 1'b1;
            if (idx_ff == '1) st_in = ST_IDLE;
         end
         ST_UPRD: begin
            raddr = lvl_ff;
            st_in = ST_UPWR;
         end
         ST_UPWR: begin
            waddr = lvl_ff; bwd = newv; swd = newv;
            bwe = !side_ff; swe = side_ff;
            rv_in = 1'b1; rpx_in = '0; rvol_in = '0; rfnd_in = 1'b0; runf_in = under;
            st_in = ST_IDLE;
         end
         ST_DOWN, ST_DLAST: begin
            // read issued at idx_ff in DOWN; data consumed in the next cycle
            if (st_ff == ST_DOWN) begin
               raddr = idx_ff;
               idx_in = idx_ff - 1'b1;
               if (idx_ff == '0) st_in = ST_DLAST;
            end
            if (!(st_ff == ST_DOWN && idx_ff == '1)) begin
               // data for level idx_ff+1 is valid; store the buy volume above it
               bacc_in = capd_pkg::sat_add(bacc_ff, brd);
               cwe = 1'b1; cwaddr = idx_ff + 1'b1; cwd = bacc_ff;
               if (brd != '0) anyb_in = 1'b1;
               if (srd != '0) anys_in = 1'b1;
            end
            if (st_ff == ST_DLAST) begin
               st_in = ST_UP; idx_in = '0; down_in = '0; found_in = 1'b0;
               psum_in = '0; pcnt_in = '0; pxacc_in = (PB+LB+17)'(base_ff);
               bvol_in = '0; bdiff_in = '0; bpx_in = '0; bdist_in = '0;
               raddr = '0; craddr = '0;
            end
         end
         ST_UP: begin
            // issue first read: level 0
            raddr = idx_ff; craddr = idx_ff;
            st_in = ST_ULAST;
         end
         ST_ULAST: begin
            // data for level idx_ff valid; read next
            raddr = idx_ff + 1'b1; craddr = idx_ff + 1'b1;
            if (trad) begin
               if (better) begin
                  found_in = 1'b1; bvol_in = vol; bdiff_in = diff;
                  bpx_in = px; bdist_in = gap;
               end
               psum_in = psum_ff + SB'(px);
               pcnt_in = pcnt_ff + 1'b1;
            end
            down_in  = ssum;
            pxacc_in = pxacc_ff + (PB+LB+17)'(tick_ff);
            idx_in   = idx_ff + 1'b1;
            if (idx_ff == '1) st_in = ST_FIN;
         end
         ST_FIN: begin
            if (!mode_ff && (!anyb_ff || !anys_ff || !found_ff)) begin
               rv_in = 1'b1; rpx_in = '0; rvol_in = '0; rfnd_in = 1'b0; runf_in = 1'b0;
               st_in = ST_IDLE;
            end else if (!found_ff) begin
               rv_in = 1'b1; rpx_in = '0; rvol_in = '0; rfnd_in = 1'b0; runf_in = 1'b0;
               st_in = ST_IDLE;
            end else if (!mode_ff) begin
               rv_in = 1'b1; rpx_in = bpx_ff; rvol_in = bvol_ff; rfnd_in = 1'b1;
               runf_in = 1'b0; st_in = ST_IDLE;
            end else begin
               div_start = 1'b1; st_in = ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_done) st_in = ST_PX;
         end
         ST_PX: begin
            rv_in = 1'b1;
            rpx_in = (qx100 > (SB+8)'({PB{1'b1}})) ? {PB{1'b1}} : qx100[PB-1:0];
            rvol_in = bvol_ff; rfnd_in = 1'b1; runf_in = 1'b0;
            st_in = ST_IDLE;
         end
         default: st_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff   <= ST_CLR;
         idx_ff  <= '0;
         rv_ff   <= 1'b0;
         ref_ff  <= '0;
         base_ff <= '0;
         tick_ff <= 16'd10;
         mode_ff <= 1'b0;
      end else begin
         st_ff  <= st_in;
         idx_ff <= idx_in;
         rv_ff  <= rv_in;
         if (csr_write) begin
            case (csr_index)
               capd_pkg::CSR_REF:  ref_ff  <= csr_data;
               capd_pkg::CSR_BASE: base_ff <= csr_data;
               capd_pkg::CSR_TICK: tick_ff <= csr_data[15:0];
               capd_pkg::CSR_MODE: mode_ff <= csr_data[0];
               default: ;
            endcase
         end
      end
      side_ff <= side_in; lvl_ff <= lvl_in; delta_ff <= delta_in;
      bacc_ff <= bacc_in; down_ff <= down_in; anyb_ff <= anyb_in; anys_ff <= anys_in;
      found_ff <= found_in; bvol_ff <= bvol_in; bdiff_ff <= bdiff_in;
      bpx_ff <= bpx_in; bdist_ff <= bdist_in; psum_ff <= psum_in; pcnt_ff <= pcnt_in;
      pxacc_ff <= pxacc_in; rpx_ff <= rpx_in; rvol_ff <= rvol_in;
      rfnd_ff <= rfnd_in; runf_ff <= runf_in;
   end

   assign busy               = (st_ff != ST_IDLE);
   assign rsp_valid          = rv_ff;
   assign rsp_price          = rpx_ff;
   assign rsp_matched_volume = rvol_ff;
   assign rsp_found          = rfnd_ff;
   assign rsp_underflow      = runf_ff;

   `CAPD_ASSERT(a_start_idle, clock, reset, start && !busy && req_op != capd_pkg::OP_UNUSED |=> busy, "start not taken")
   `CAPD_ASSERT(a_rsp_one, clock, reset, rsp_valid |=> !rsp_valid, "result held twice")
   `CAPD_ASSERT(a_uf_update, clock, reset, rsp_valid && rsp_underflow |-> !rsp_found, "underflow on compute")
endmodule
